[design/b32ad_pkg.sv]
// Shared types, codes and constants for the base32 address decoder.
package b32ad_pkg;

   localparam int KEY_BYTES_DEFAULT   = 32;
   localparam int CHECK_BYTES_DEFAULT = 4;
   localparam int QUEUE_DEPTH         = 4;
   localparam int QUEUE_PTR_W         = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W         = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] PAD_CHAR  = 8'h3D;
   localparam logic [5:0] COUNT_MAX = 6'd63;

   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_INVALID = 2'd1,
      STATUS_LENGTH  = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] text_char;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic       result_kind;
      logic [7:0] data_byte;
      logic [1:0] status_code;
      logic       last_result;
   } rsp_type;

   typedef struct packed {
      logic first;
      logic second;
   } push_type;

   typedef struct packed {
      logic       valid;
      logic [4:0] value;
   } symbol_type;

   function automatic symbol_type symbol_value(input logic [7:0] c);
      symbol_type s;
      s.valid = 1'b1;
      s.value = 5'd0;
      if (c inside {[8'h41:8'h5A]}) begin
         s.value = 5'(c - 8'h41);
      end else if (c inside {[8'h61:8'h7A]}) begin
         s.value = 5'(c - 8'h61);
      end else if (c inside {[8'h32:8'h37]}) begin
         s.value = 5'(c - 8'h32 + 8'd26);
      end else begin
         s.valid = 1'b0;
      end
      return s;
   endfunction

endpackage

[design/b32ad_decode.sv]
// Input register, bit accumulator and per-character decode into up to two responses.
module b32ad_decode #(
   parameter int KEY_BYTES   = b32ad_pkg::KEY_BYTES_DEFAULT,
   parameter int CHECK_BYTES = b32ad_pkg::CHECK_BYTES_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  b32ad_pkg::req_type  req_data,
   input  logic                space_ok,
   output b32ad_pkg::push_type push,
   output b32ad_pkg::rsp_type  slot0,
   output b32ad_pkg::rsp_type  slot1
);

   localparam logic [5:0] KEY_COUNT   = 6'(KEY_BYTES);
   localparam logic [5:0] TOTAL_COUNT = 6'(KEY_BYTES + CHECK_BYTES);

   logic               in_valid_ff, in_valid_in;
   b32ad_pkg::req_type in_item_ff, in_item_in;

   logic [6:0] acc_ff, acc_in;
   logic [2:0] bits_ff, bits_in;
   logic [5:0] cnt_ff, cnt_in;
   logic       pad_ff, pad_in;
   logic       err_ff, err_in;

   logic                  take;
   b32ad_pkg::symbol_type sym;
   logic [11:0]           acc_wide;
   logic [3:0]            bits_sum;
   logic [2:0]            bits_rest;
   logic [7:0]            out_byte;
   logic                  emit;
   b32ad_pkg::rsp_type    data_rsp, status_rsp;

   assign take      = in_valid_ff && space_ok;
   assign req_ready = !in_valid_ff || take;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_item_in  = req_data;
      end else if (take) begin
         in_valid_in = 1'b0;
      end
   end

   assign sym      = b32ad_pkg::symbol_value(in_item_ff.text_char);
   assign acc_wide = {acc_ff, sym.value};
   assign bits_sum = {1'b0, bits_ff} + 4'd5;
   assign out_byte = 8'(acc_wide >> (bits_sum - 4'd8));

   always_comb begin
      acc_in    = acc_ff;
      bits_in   = bits_ff;
      cnt_in    = cnt_ff;
      pad_in    = pad_ff;
      err_in    = err_ff;
      emit      = 1'b0;
      bits_rest = bits_sum[2:0];
      if (!err_ff) begin
         if (in_item_ff.text_char == b32ad_pkg::PAD_CHAR) begin
            pad_in = 1'b1;
         end else if (pad_ff || !sym.valid) begin
            err_in = 1'b1;
         end else begin
            if (bits_sum[3]) begin
               bits_rest = 3'(bits_sum - 4'd8);
               emit      = (cnt_ff < KEY_COUNT);
               if (cnt_ff != b32ad_pkg::COUNT_MAX) begin
                  cnt_in = cnt_ff + 6'd1;
               end
            end
            bits_in = bits_rest;
            acc_in  = acc_wide[6:0] & ~(7'h7F << bits_rest);
         end
      end
   end

   always_comb begin
      data_rsp             = '0;
      data_rsp.result_kind = b32ad_pkg::KIND_DATA;
      data_rsp.data_byte   = out_byte;

      status_rsp             = '0;
      status_rsp.result_kind = b32ad_pkg::KIND_STATUS;
      status_rsp.last_result = 1'b1;
      if (err_in) begin
         status_rsp.status_code = b32ad_pkg::STATUS_INVALID;
      end else if (cnt_in != TOTAL_COUNT) begin
         status_rsp.status_code = b32ad_pkg::STATUS_LENGTH;
      end else begin
         status_rsp.status_code = b32ad_pkg::STATUS_OK;
      end

      slot0       = emit ? data_rsp : status_rsp;
      slot1       = status_rsp;
      push.first  = take && (emit || in_item_ff.end_of_text);
      push.second = take && emit && in_item_ff.end_of_text;
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      if (reset) begin
         in_valid_ff <= 1'b0;
         acc_ff      <= '0;
         bits_ff     <= '0;
         cnt_ff      <= '0;
         pad_ff      <= 1'b0;
         err_ff      <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (take) begin
            if (in_item_ff.end_of_text) begin
               acc_ff  <= '0;
               bits_ff <= '0;
               cnt_ff  <= '0;
               pad_ff  <= 1'b0;
               err_ff  <= 1'b0;
            end else begin
               acc_ff  <= acc_in;
               bits_ff <= bits_in;
               cnt_ff  <= cnt_in;
               pad_ff  <= pad_in;
               err_ff  <= err_in;
            end
         end
      end
   end

endmodule

[design/b32ad_queue.sv]
// Small response queue taking up to two entries per cycle and giving one per cycle while rsp_ready is high.
module b32ad_queue (
   input  logic                clock,
   input  logic                reset,
   input  b32ad_pkg::push_type push,
   input  b32ad_pkg::rsp_type  slot0,
   input  b32ad_pkg::rsp_type  slot1,
   output logic                space_ok,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output b32ad_pkg::rsp_type  rsp_data
);

   localparam int PW = b32ad_pkg::QUEUE_PTR_W;
   localparam int CW = b32ad_pkg::QUEUE_CNT_W;

   b32ad_pkg::rsp_type entries_ff [b32ad_pkg::QUEUE_DEPTH];
   logic [PW-1:0]      wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in, wr_next;
   logic [CW-1:0]      count_ff, count_in;
   logic               pop;

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = entries_ff[rd_ptr_ff];
   assign space_ok  = (count_ff <= CW'(b32ad_pkg::QUEUE_DEPTH - 2));
   assign wr_next   = wr_ptr_ff + PW'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PW'(push.first) + PW'(push.second);
      rd_ptr_in = rd_ptr_ff + PW'(pop);
      count_in  = count_ff + CW'(push.first) + CW'(push.second) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.first) begin
         entries_ff[wr_ptr_ff] <= slot0;
      end
      if (push.second) begin
         entries_ff[wr_next] <= slot1;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(b32ad_pkg::QUEUE_DEPTH))
      else $error("response queue overflow");

   a_second_needs_first : assert property (@(posedge clock) disable iff (reset)
      push.second |-> push.first)
      else $error("second push without first");

   a_push_needs_room : assert property (@(posedge clock) disable iff (reset)
      push.first |-> space_ok)
      else $error("push into full queue");

   a_ptr_count_agree : assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == CW'(b32ad_pkg::QUEUE_DEPTH))
      == (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");

endmodule

[design/base32_address_decoder_unit.sv]
// Top level of the base32 address decoder.
//
// Requests arrive on req_ (valid/ready), one text character each, with
// end_of_text on the final character of an address. Responses leave on rsp_
// (valid/ready): one data byte for every completed key byte, then a status
// response with last_result set after the end character.
// A request accepted is held in the input register, then decoded into a
// four-entry response queue, from which its first response is taken.
// Throughput is one request per cycle while the receiver keeps up; the
// decode logic consumes a request only when the queue has room for two
// responses, so an end character that also finishes a key byte takes two
// response slots of output bandwidth.
// When the receiver stalls, the queue fills and req_ready drops after the
// input register is occupied; nothing is lost.
// Reset empties the queue and input register and clears the accumulator,
// byte count, padding and error flags; all of this but the queue and input
// register is also cleared after every end character.
module base32_address_decoder_unit #(
   parameter int KEY_BYTES   = b32ad_pkg::KEY_BYTES_DEFAULT,
   parameter int CHECK_BYTES = b32ad_pkg::CHECK_BYTES_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  b32ad_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output b32ad_pkg::rsp_type rsp_data
);

   logic                space_ok;
   b32ad_pkg::push_type push;
   b32ad_pkg::rsp_type  slot0, slot1;

   b32ad_decode #(
      .KEY_BYTES   (KEY_BYTES),
      .CHECK_BYTES (CHECK_BYTES)
   ) u_decode (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .space_ok  (space_ok),
      .push      (push),
      .slot0     (slot0),
      .slot1     (slot1)
   );

   b32ad_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .slot0     (slot0),
      .slot1     (slot1),
      .space_ok  (space_ok),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
